// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the committee block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define AST_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("committee check failed");
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("committee check failed");
`endif

// ----- rtl/hsc_pkg.sv -----
// ---------------------------------------------------------------------------
// Committee selection package
// Item types, command and status groups, constants and the round table.
// ---------------------------------------------------------------------------
package hsc_pkg;

  typedef struct packed {
    logic [63:0] key_w0;
    logic [63:0] key_w1;
    logic [63:0] key_w2;
    logic [63:0] key_w3;
    logic        last_key;
  } in_item_t;

  typedef struct packed {
    logic [63:0] member_w0;
    logic [63:0] member_w1;
    logic [63:0] member_w2;
    logic [63:0] member_w3;
    logic [5:0]  rank;
    logic        last_member;
    logic        overflowed;
  } out_item_t;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PREV0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREV1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREV2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PREV3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXC   = 3'd5;

  localparam logic [119:0] SEED_TAG = 120'h53432d434f4d4d49545445452d5630;
  localparam logic [255:0] SHA_IV = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
                                     32'ha54ff53a, 32'h510e527f, 32'h9b05688c,
                                     32'h1f83d9ab, 32'h5be0cd19};

  typedef enum logic [1:0] {
    BLK_SEED,
    BLK_SCORE1,
    BLK_SCORE2,
    BLK_DIGEST
  } blk_sel_t;

  typedef struct packed {
    logic       capture;
    logic       hash_start;
    logic       use_iv;
    blk_sel_t   blk_sel;
    logic       seed_load;
    logic       store;
    logic       scan_clear;
    logic       scan_rd;
    logic       emit;
    logic       clear_marks;
    logic [6:0] addr;
    logic [5:0] rank;
    logic       last_member;
    logic       ovf;
  } cmd_t;

  typedef struct packed {
    logic       hash_done;
    logic       out_busy;
    logic [6:0] size_cap;
  } sts_t;

  function automatic logic [31:0] sha_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/hsc_sha_core.sv -----
// ---------------------------------------------------------------------------
// SHA-256 compression unit
// One round per cycle over a 16-word schedule window, then the chaining add.
// ---------------------------------------------------------------------------
module hsc_sha_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic         use_iv,
  input  logic [511:0] block,
  output logic [255:0] digest,
  output logic         done
);
  import hsc_pkg::*;

  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [5:0]  round_r;
  logic        busy_r;
  logic        fin_r;
  logic        done_r;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] t1, t2, w_new;

  always_comb begin
    t1 = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25)) +
         ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + sha_k(round_r) + w_r[0];
    t2 = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22)) +
         ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    w_new = w_r[0] + (rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3)) + w_r[9] +
            (rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      fin_r   <= 1'b0;
      done_r  <= 1'b0;
      round_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        round_r <= '0;
      end else if (busy_r) begin
        round_r <= round_r + 6'd1;
        if (round_r == 6'd63) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 16; i++) begin
        w_r[i] <= block[511 - 32*i -: 32];
      end
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= use_iv ? SHA_IV[255 - 32*i -: 32] : h_r[i];
        if (use_iv) begin
          h_r[i] <= SHA_IV[255 - 32*i -: 32];
        end
      end
    end else if (busy_r) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_new;
      v_r[0] <= t1 + t2;
      v_r[1] <= v_r[0];
      v_r[2] <= v_r[1];
      v_r[3] <= v_r[2];
      v_r[4] <= v_r[3] + t1;
      v_r[5] <= v_r[4];
      v_r[6] <= v_r[5];
      v_r[7] <= v_r[6];
    end else if (fin_r) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= h_r[i] + v_r[i];
      end
    end
  end

  assign digest = {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4], h_r[5], h_r[6], h_r[7]};
  assign done   = done_r;

endmodule

// ----- rtl/hsc_datapath.sv -----
// ---------------------------------------------------------------------------
// Committee selection datapath
// Registers, message builder, entry memory, minimum search and result register.
// ---------------------------------------------------------------------------
module hsc_datapath #(
  parameter int MAX_VALIDATORS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  hsc_pkg::in_item_t        in_data,
  input  logic                     cfg_valid,
  input  logic [2:0]               cfg_index,
  input  logic [63:0]              cfg_data,
  input  hsc_pkg::cmd_t            cmd,
  output hsc_pkg::sts_t            sts,
  output logic                     out_valid,
  input  logic                     out_ready,
  output hsc_pkg::out_item_t       out_data
);
  import hsc_pkg::*;

  localparam int IDX_W = (MAX_VALIDATORS > 1) ? $clog2(MAX_VALIDATORS) : 1;

  logic [63:0]  prev_r [4];
  logic [63:0]  height_r;
  logic [6:0]   maxc_r;
  logic [255:0] key_r;
  logic [255:0] seed_r;
  logic [511:0] mem [MAX_VALIDATORS];
  logic [511:0] rd_data_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic         rd_v_r;
  logic [511:0] best_r;
  logic [IDX_W-1:0] best_idx_r;
  logic         have_r;
  logic [MAX_VALIDATORS-1:0] mark_r;
  logic         out_valid_r;
  out_item_t    out_r;
  logic [511:0] blk;
  logic [255:0] digest;
  logic         hash_done;
  logic [63:0]  height_le;
  logic         take;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      height_le[63 - 8*i -: 8] = height_r[8*i +: 8];
    end
    case (cmd.blk_sel)
      BLK_SEED:   blk = {SEED_TAG, prev_r[0], prev_r[1], prev_r[2], prev_r[3], height_le,
                         8'h80, 64'd440};
      BLK_SCORE1: blk = {seed_r, key_r};
      BLK_SCORE2: blk = {8'h80, 440'd0, 64'd512};
      BLK_DIGEST: blk = {digest, 8'h80, 184'd0, 64'd256};
      default:    blk = '0;
    endcase
  end

  hsc_sha_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.hash_start),
    .use_iv (cmd.use_iv),
    .block  (blk),
    .digest (digest),
    .done   (hash_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        prev_r[i] <= '0;
      end
      height_r <= '0;
      maxc_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PREV0:  prev_r[0] <= cfg_data;
        CFG_PREV1:  prev_r[1] <= cfg_data;
        CFG_PREV2:  prev_r[2] <= cfg_data;
        CFG_PREV3:  prev_r[3] <= cfg_data;
        CFG_HEIGHT: height_r  <= cfg_data;
        CFG_MAXC:   maxc_r    <= cfg_data[6:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_r <= {in_data.key_w0, in_data.key_w1, in_data.key_w2, in_data.key_w3};
    end
    if (cmd.seed_load) begin
      seed_r <= digest;
    end
    if (cmd.store) begin
      mem[cmd.addr[IDX_W-1:0]] <= {digest, key_r};
    end
    rd_data_r <= mem[cmd.addr[IDX_W-1:0]];
    rd_idx_r  <= cmd.addr[IDX_W-1:0];
    if (take) begin
      best_r     <= rd_data_r;
      best_idx_r <= rd_idx_r;
    end
    if (cmd.emit) begin
      out_r.member_w0   <= best_r[255:192];
      out_r.member_w1   <= best_r[191:128];
      out_r.member_w2   <= best_r[127:64];
      out_r.member_w3   <= best_r[63:0];
      out_r.rank        <= cmd.rank;
      out_r.last_member <= cmd.last_member;
      out_r.overflowed  <= cmd.ovf;
    end
  end

  assign take = rd_v_r && !mark_r[rd_idx_r] && (!have_r || (rd_data_r < best_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r      <= 1'b0;
      have_r      <= 1'b0;
      mark_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.scan_rd;
      if (cmd.scan_clear) begin
        have_r <= 1'b0;
      end else if (take) begin
        have_r <= 1'b1;
      end
      if (cmd.clear_marks) begin
        mark_r <= '0;
      end else if (cmd.emit) begin
        mark_r[best_idx_r] <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.hash_done = hash_done;
  assign sts.out_busy  = out_valid_r;
  assign sts.size_cap  = maxc_r;
  assign out_valid     = out_valid_r;
  assign out_data      = out_r;

endmodule

// ----- rtl/hsc_ctrl.sv -----
// ---------------------------------------------------------------------------
// Committee selection controller
// Sequences the hash passes per key, then the selection scans and emission.
// ---------------------------------------------------------------------------
module hsc_ctrl #(
  parameter int MAX_VALIDATORS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  hsc_pkg::sts_t sts,
  output hsc_pkg::cmd_t cmd
);
  import hsc_pkg::*;

  localparam int CNT_W = $clog2(MAX_VALIDATORS + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_HSTART, ST_HWAIT, ST_SETUP, ST_SCAN, ST_DRAIN, ST_EMIT, ST_OWAIT
  } state_t;

  typedef enum logic [2:0] {
    PH_SEED1, PH_SEED2, PH_SC1, PH_SC2, PH_SC3
  } phase_t;

  state_t           state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic [6:0]       rank_r, rank_nxt;
  logic             ovf_r, ovf_nxt;
  logic             last_r, last_nxt;
  logic [6:0]       cnt7;
  logic [6:0]       size;

  assign cnt7 = 7'(count_r);
  assign size = (sts.size_cap < cnt7) ? sts.size_cap : cnt7;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    count_nxt = count_r;
    scan_nxt  = scan_r;
    rank_nxt  = rank_r;
    ovf_nxt   = ovf_r;
    last_nxt  = last_r;
    cmd       = '0;
    cmd.blk_sel     = BLK_SEED;
    cmd.addr        = 7'(count_r);
    cmd.rank        = rank_r[5:0];
    cmd.last_member = (rank_r + 7'd1) == size;
    cmd.ovf         = ovf_r;
    in_ready  = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          last_nxt    = in_last;
          if (count_r == CNT_W'(MAX_VALIDATORS)) begin
            ovf_nxt = 1'b1;
            if (in_last) begin
              state_nxt = ST_SETUP;
            end
          end else begin
            phase_nxt = (count_r == '0) ? PH_SEED1 : PH_SC1;
            state_nxt = ST_HSTART;
          end
        end
      end
      ST_HSTART: begin
        cmd.hash_start = 1'b1;
        case (phase_r)
          PH_SEED1: begin cmd.blk_sel = BLK_SEED;   cmd.use_iv = 1'b1; end
          PH_SEED2: begin cmd.blk_sel = BLK_DIGEST; cmd.use_iv = 1'b1; end
          PH_SC1:   begin cmd.blk_sel = BLK_SCORE1; cmd.use_iv = 1'b1; end
          PH_SC2:   begin cmd.blk_sel = BLK_SCORE2; cmd.use_iv = 1'b0; end
          default:  begin cmd.blk_sel = BLK_DIGEST; cmd.use_iv = 1'b1; end
        endcase
        state_nxt = ST_HWAIT;
      end
      ST_HWAIT: begin
        if (sts.hash_done) begin
          state_nxt = ST_HSTART;
          case (phase_r)
            PH_SEED1: phase_nxt = PH_SEED2;
            PH_SEED2: begin
              cmd.seed_load = 1'b1;
              phase_nxt     = PH_SC1;
            end
            PH_SC1:   phase_nxt = PH_SC2;
            PH_SC2:   phase_nxt = PH_SC3;
            default: begin
              cmd.store = 1'b1;
              count_nxt = count_r + CNT_W'(1);
              state_nxt = last_r ? ST_SETUP : ST_IDLE;
            end
          endcase
        end
      end
      ST_SETUP: begin
        if (rank_r == size) begin
          cmd.clear_marks = 1'b1;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          rank_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          cmd.scan_clear = 1'b1;
          scan_nxt  = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        cmd.addr    = 7'(scan_r);
        scan_nxt    = scan_r + CNT_W'(1);
        if ((scan_r + CNT_W'(1)) == count_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        rank_nxt  = rank_r + 7'd1;
        state_nxt = ST_OWAIT;
      end
      ST_OWAIT: begin
        if (!sts.out_busy) begin
          state_nxt = ST_SETUP;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_SEED1;
      count_r <= '0;
      scan_r  <= '0;
      rank_r  <= '0;
      ovf_r   <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      scan_r  <= scan_nxt;
      rank_r  <= rank_nxt;
      ovf_r   <= ovf_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

// ----- rtl/hash_sortition_committee_unit.sv -----
// ---------------------------------------------------------------------------
// Hash sortition committee selection
// Hashes each validator key against a per-list seed and emits the committee.
// ---------------------------------------------------------------------------
// Keys arrive on the in_ channel, one item per key, the final one marked by
// last_key. Settings are written on the cfg_ channel, which is always ready.
// Each SHA-256 compression runs in the one-round-per-cycle unit.
// The first key of a list costs five compressions (two for the seed, three
// for the score) before in_ready returns; every further key costs three
// compressions. Keys beyond MAX_VALIDATORS are dropped and flag overflowed.
// After the last key, each committee member takes one scan of the stored
// entries through the memory read port, and the next scan waits until the
// receiver takes the result. While the receiver stalls, the result
// register holds and no new key is taken.
// The next list starts once the final member is taken. Reset clears the
// settings, the key count and the overflow flag; no memory clearing pass is
// needed.
// ---------------------------------------------------------------------------
module hash_sortition_committee_unit #(
  parameter int MAX_VALIDATORS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hsc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hsc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import hsc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  hsc_ctrl #(.MAX_VALIDATORS(MAX_VALIDATORS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_key),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hsc_datapath #(.MAX_VALIDATORS(MAX_VALIDATORS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/hsc_checker.sv -----
// ---------------------------------------------------------------------------
// Committee selection port checker
// Concurrent checks on the top-level channels, attached by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hsc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input hsc_pkg::out_item_t out_data
);
  `AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `AST_SAME(a_no_take_while_emitting, out_valid, !in_ready)
  `AST_NEXT(a_last_ends, out_valid && out_ready && out_data.last_member, !out_valid)
  `AST_NEXT(a_key_no_result, in_valid && in_ready, !out_valid)
endmodule

bind hash_sortition_committee_unit hsc_checker u_hsc_checker (.*);
